// File: sv/mprq_pkg.sv
// Shared types and constants for the multilevel priority ready queue.
// No dependencies; imported by the controller, datapath and top level.
package mprq_pkg;

  localparam int unsigned OP_W     = 1;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned TASK_W   = 7;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_OUT
  } state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic exec;     // update pointers, write or read the storage
    logic load;     // load the output register
  } cmd_t;

endpackage

// File: sv/multilevel_priority_ready_queue.sv
// Top level of the multilevel priority ready queue.
// Depends on mprq_pkg, mprq_ctrl and mprq_dpath.
//
// Keeps one FIFO of task ids per priority level, level 0 most urgent.
// Input channel: in_valid_i / in_stall_o with opcode_i, priority_level_i
// and task_number_i. Enqueue appends the task to its level's FIFO;
// dequeue pops the head of the most urgent non-empty level.
// Output channel: out_valid_o / out_stall_i with next_task_o and status_o.
// Every input word gives exactly one output word: status ok, empty
// (dequeue with all levels empty, task 0) or dropped (enqueue to a full
// or nonexistent level, task 0). Enqueue results always carry task 0.
// One word is handled at a time, in the sequencer's steps: capture,
// storage access with a registered read, output load and hand-off. The
// result is valid in the hand-off state, and the next input is accepted
// only after the result has left. While the receiver stalls, the result
// and its status hold and no new input is accepted. Reset empties all
// levels; no clearing pass is needed because only read data from entries
// already written reaches the output.
module multilevel_priority_ready_queue
  import mprq_pkg::*;
#(
  parameter int unsigned PRIORITY_LEVELS = 8,
  parameter int unsigned QUEUE_DEPTH     = 64,
  parameter int unsigned TASK_ID_BITS    = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     opcode_i,
  input  logic [LEVEL_W-1:0]  priority_level_i,
  input  logic [TASK_W-1:0]   task_number_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [TASK_W-1:0]   next_task_o,
  output logic [STATUS_W-1:0] status_o
);

  cmd_t cmd;

  mprq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  mprq_dpath #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .TASK_ID_BITS    (TASK_ID_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .opcode_i         (opcode_i),
    .priority_level_i (priority_level_i),
    .task_number_i    (task_number_i),
    .next_task_o      (next_task_o),
    .status_o         (status_o)
  );

endmodule

// File: sv/mprq_ctrl.sv
// Sequencing FSM for the multilevel priority ready queue.
// Depends on mprq_pkg; drives the handshake and the datapath commands.
module mprq_ctrl
  import mprq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        // storage read data is registered by now
        cmd_o.load = 1'b1;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/mprq_dpath.sv
// Datapath: per-level head/tail/count registers, task storage memory,
// priority encoder and output register. Depends on mprq_pkg.
module mprq_dpath
  import mprq_pkg::*;
#(
  parameter int unsigned PRIORITY_LEVELS = 8,
  parameter int unsigned QUEUE_DEPTH     = 64,
  parameter int unsigned TASK_ID_BITS    = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic [OP_W-1:0]     opcode_i,
  input  logic [LEVEL_W-1:0]  priority_level_i,
  input  logic [TASK_W-1:0]   task_number_i,
  output logic [TASK_W-1:0]   next_task_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned LVL_W     = $clog2(PRIORITY_LEVELS);
  localparam int unsigned PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ADDR_W    = LVL_W + PTR_W;
  localparam int unsigned MEM_DEPTH = PRIORITY_LEVELS << PTR_W;

  // captured word
  op_e                     op_q;
  logic [LEVEL_W-1:0]      lvl_q;
  logic [TASK_ID_BITS-1:0] task_q;

  logic [PTR_W-1:0] head_q  [PRIORITY_LEVELS];
  logic [PTR_W-1:0] tail_q  [PRIORITY_LEVELS];
  logic [CNT_W-1:0] count_q [PRIORITY_LEVELS];

  logic [TASK_ID_BITS-1:0] mem [MEM_DEPTH];
  logic [TASK_ID_BITS-1:0] rdata_q;

  logic                hit_q;
  status_e             result_q;
  logic [TASK_W-1:0]   next_task_q;
  logic [STATUS_W-1:0] status_q;

  logic [PRIORITY_LEVELS-1:0] nonempty;
  logic [LVL_W-1:0]           found_lvl;
  logic                       found;
  logic [LVL_W-1:0]           sel_lvl;
  logic                       lvl_ok;
  logic [PTR_W-1:0]           sel_head, sel_tail, sel_ptr;
  logic [CNT_W-1:0]           sel_count;
  logic                       full;
  logic                       do_write, do_read;
  logic [ADDR_W-1:0]          addr;
  status_e                    result_d;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(opcode_i);
      lvl_q  <= priority_level_i;
      task_q <= TASK_ID_BITS'(32'(task_number_i));
    end
  end

  // priority encoder, lowest non-empty level wins
  always_comb begin
    found     = 1'b0;
    found_lvl = '0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      nonempty[i] = (count_q[i] != '0);
    end
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        found     = 1'b1;
        found_lvl = LVL_W'(i);
      end
    end
  end

  always_comb begin
    lvl_ok    = (32'(lvl_q) < PRIORITY_LEVELS);
    sel_lvl   = (op_q == OP_DEQUEUE) ? found_lvl : LVL_W'(32'(lvl_q));
    sel_head  = head_q[sel_lvl];
    sel_tail  = tail_q[sel_lvl];
    sel_count = count_q[sel_lvl];
    full      = (sel_count == CNT_W'(QUEUE_DEPTH));
    do_write  = (op_q == OP_ENQUEUE) && lvl_ok && !full;
    do_read   = (op_q == OP_DEQUEUE) && found;
    sel_ptr   = (op_q == OP_DEQUEUE) ? sel_head : sel_tail;
    addr      = {sel_lvl, sel_ptr};
    if (op_q == OP_ENQUEUE) begin
      result_d = do_write ? STATUS_OK : STATUS_DROPPED;
    end else begin
      result_d = found ? STATUS_OK : STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else if (cmd_i.exec) begin
      if (do_write) begin
        tail_q[sel_lvl]  <= advance(sel_tail);
        count_q[sel_lvl] <= sel_count + 1'b1;
      end
      if (do_read) begin
        head_q[sel_lvl]  <= advance(sel_head);
        count_q[sel_lvl] <= sel_count - 1'b1;
      end
    end
  end

  // task storage, a registered read on every operation, a write on an accepted enqueue
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && do_write) begin
      mem[addr] <= task_q;
    end
    if (cmd_i.exec) begin
      rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      hit_q    <= do_read;
      result_q <= result_d;
    end
    if (cmd_i.load) begin
      next_task_q <= hit_q ? TASK_W'(32'(rdata_q)) : '0;
      status_q    <= result_q;
    end
  end

  assign next_task_o = next_task_q;
  assign status_o    = status_q;

endmodule
